// ----- rtl/core/smscm_pkg.sv -----
package smscm_pkg;

  // sample and field widths
  localparam int SAMPLE_BITS    = 24;
  localparam int FRAC_BITS      = 19;
  localparam int GAIN_FRAC_BITS = 14;
  localparam int GAIN_W         = 16;
  localparam int PEAK_W         = SAMPLE_BITS - 1;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = GAIN_W;
  localparam logic [CFG_IDX_W-1:0] CFG_MASTER_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASTER_MUTE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOFT_CLIP_EN = 2'd2;
  localparam logic [GAIN_W-1:0]    GAIN_RESET       = 16'd16384;

  // knee and span of the soft clip, in sample units
  localparam int ONE_Q = 1 << FRAC_BITS;
  localparam int KNEE  = ((95 << FRAC_BITS) + 50) / 100;
  localparam int SPAN  = ONE_Q - KNEE;

  // gained magnitude, full scale times the largest gain needs two extra bits
  localparam int MAG_W  = SAMPLE_BITS;
  localparam int PROD_W = MAG_W + GAIN_W;
  localparam int M1_W   = SAMPLE_BITS + 2;

  // reciprocal division of (excess << 16) by SPAN
  localparam int RANGE_SH = 3;
  localparam int DIFF_W   = $clog2(SPAN << RANGE_SH);
  localparam int RECIP_SH = DIFF_W;
  localparam longint unsigned RECIP = (64'd1 << (16 + RECIP_SH)) / SPAN;
  localparam int RECIP_W  = $clog2(RECIP + 1);
  localparam int RMUL_W   = DIFF_W + RECIP_W;
  localparam int QEST_W   = RMUL_W - RECIP_SH;
  localparam int SPAN_W   = $clog2(SPAN + 1);
  localparam int PRODC_W  = QEST_W + SPAN_W;
  localparam int NUM_W    = (DIFF_W + 16 > PRODC_W) ? DIFF_W + 17 : PRODC_W + 1;

  // tanh table, Q24 values
  localparam int TAB_N    = 256;
  localparam int TAB_IW   = $clog2(TAB_N);
  localparam int TAB_LAST = TAB_N - 1;
  localparam int TAB_W    = 25;
  localparam int POS_W    = QEST_W + TAB_IW;
  localparam int IDXF_W   = POS_W - 16 - RANGE_SH;
  localparam int DT_W     = TAB_W + 1;
  localparam int P_W      = DT_W + 16 + 1;
  localparam int V_W      = P_W - 16;
  localparam int TM_W     = TAB_W + SPAN_W;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [PEAK_W-1:0]             peak_t;
  typedef logic [TAB_W-1:0]              tab_entry_t;
  typedef tab_entry_t [TAB_N-1:0]        tab_t;

  typedef struct packed {
    logic    func;
    sample_t left_in;
    sample_t right_in;
    logic    last_of_block;
  } in_t;

  typedef struct packed {
    sample_t left_out;
    sample_t right_out;
    peak_t   level_left;
    peak_t   level_right;
    peak_t   hold_left;
    peak_t   hold_right;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic load;
  } smscm_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FIN
  } ctrl_state_e;

  // restoring shift-subtract quotient, used only while building the table
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] dvs);
    logic [63:0] quo;
    logic [64:0] rmd;
    int          b;
    quo = '0;
    rmd = '0;
    for (b = 63; b >= 0; b--) begin
      rmd = {rmd[63:0], num[b]};
      if (rmd >= {1'b0, dvs}) begin
        rmd    = rmd - {1'b0, dvs};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // tanh at evenly spaced points from 0 to 8: e to the minus x over 16 by series,
  // squared five times, then (1 - t) over (1 + t)
  function automatic tab_t tanh_table_build();
    tab_t        tab;
    logic [63:0] z;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] den;
    logic [63:0] q30;
    int          i;
    int          k;
    int          s;
    q30 = 64'd1 << 30;
    tab = '0;
    for (i = 0; i < TAB_N; i++) begin
      z    = udiv64(64'(i) << 29, 64'(TAB_N - 1));
      sum  = q30;
      term = q30;
      for (k = 1; k <= 14; k++) begin
        term = udiv64((term * z) >> 30, 64'(k));
        if (k[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      for (s = 0; s < 5; s++) begin
        sum = (sum * sum + (q30 >> 1)) >> 30;
      end
      den    = q30 + sum;
      tab[i] = TAB_W'(udiv64(((q30 - sum) << 24) + (den >> 1), den));
    end
    return tab;
  endfunction

  localparam tab_t TANH_TAB = tanh_table_build();

endpackage

// ----- rtl/core/smscm_lane.sv -----
module smscm_lane (
  input  logic                          clk_i,
  input  smscm_pkg::sample_t            sample_i,
  input  logic [smscm_pkg::GAIN_W-1:0]  gain_i,
  input  logic                          mute_i,
  input  logic                          clip_en_i,
  output smscm_pkg::sample_t            res_o
);
  import smscm_pkg::*;

  logic              neg;
  logic [MAG_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  logic              neg_q;
  logic [M1_W-1:0]   m1_q;

  logic [M1_W-1:0]   excess;
  logic              above_d, above_q;
  logic              sat_d, sat_q;
  logic [DIFF_W-1:0] diff_q;
  logic [RMUL_W-1:0] rmul_d, rmul_q;

  logic [QEST_W-1:0]  qest;
  logic [QEST_W-1:0]  qest_q;
  logic [PRODC_W-1:0] prodc_d, prodc_q;

  logic [NUM_W-1:0]  rem;
  logic [QEST_W-1:0] over_d, over_q;

  logic [POS_W-1:0]  pos;
  logic [IDXF_W-1:0] idx_full;
  logic [TAB_IW-1:0] idx_lo, idx_hi;
  logic              edge_hit;
  tab_entry_t        a_d, a_q;
  logic signed [DT_W-1:0] dt_d, dt_q;
  logic [15:0]       fr_q;

  logic signed [P_W-1:0] p_d, p_q;

  logic [P_W-1:0]        pabs;
  logic [V_W-1:0]        smag;
  logic signed [V_W-1:0] step, v;
  tab_entry_t            t_d, t_q;

  logic [TM_W-1:0] tm_d, tm_q;

  logic [TM_W:0]   rnd;
  logic [M1_W-1:0] shaped, magf;
  sample_t         res_d, res_q;

  // stage 1: magnitude times gain, rounded
  assign neg  = sample_i[SAMPLE_BITS-1];
  assign mag  = neg ? (MAG_W'(0) - MAG_W'(sample_i)) : MAG_W'(sample_i);
  assign prod = PROD_W'(mag) * PROD_W'(gain_i) + PROD_W'(1 << (GAIN_FRAC_BITS - 1));

  // stage 2: excess over knee, reciprocal estimate
  assign excess  = m1_q - M1_W'(KNEE);
  assign above_d = m1_q > M1_W'(KNEE);
  assign sat_d   = excess >= M1_W'(SPAN << RANGE_SH);
  assign rmul_d  = RMUL_W'(excess[DIFF_W-1:0]) * RMUL_W'(RECIP);

  // stage 3: back-multiply the estimate
  assign qest    = rmul_q[RMUL_W-1:RECIP_SH];
  assign prodc_d = PRODC_W'(qest) * PRODC_W'(SPAN);

  // stage 4: one-step correction of the quotient
  assign rem    = (NUM_W'(diff_q) << 16) - NUM_W'(prodc_q);
  assign over_d = qest_q + QEST_W'(rem >= NUM_W'(SPAN));

  // stage 5: table position and entry reads
  assign pos      = POS_W'(over_q) * POS_W'(TAB_LAST);
  assign idx_full = pos[POS_W-1:16+RANGE_SH];
  assign idx_lo   = idx_full[TAB_IW-1:0];
  assign idx_hi   = idx_lo + 1'b1;
  assign edge_hit = sat_q || (idx_full >= IDXF_W'(TAB_LAST));

  always_comb begin
    if (edge_hit) begin
      a_d  = TANH_TAB[TAB_IW'(TAB_LAST)];
      dt_d = '0;
    end else begin
      a_d  = TANH_TAB[idx_lo];
      dt_d = $signed({1'b0, TANH_TAB[idx_hi]}) - $signed({1'b0, TANH_TAB[idx_lo]});
    end
  end

  // stage 6: interpolation product
  assign p_d = P_W'(dt_q) * P_W'($signed({1'b0, fr_q}));

  // stage 7: truncate toward zero, add base entry and clamp a negative sum to zero
  assign pabs = p_q[P_W-1] ? P_W'(-p_q) : P_W'(p_q);
  assign smag = pabs[P_W-1:16];
  assign step = p_q[P_W-1] ? -$signed(smag) : $signed(smag);
  assign v    = $signed(V_W'(a_q)) + step;
  assign t_d  = v[V_W-1] ? '0 : v[TAB_W-1:0];

  // stage 8: scale tanh by span
  assign tm_d = TM_W'(t_q) * TM_W'(SPAN);

  // stage 9: select shaped or plain magnitude, saturate, restore sign, or force zero on mute
  assign rnd    = (TM_W + 1)'(tm_q) + (TM_W + 1)'(1 << 23);
  assign shaped = M1_W'(rnd[TM_W:24]) + M1_W'(KNEE);
  assign magf   = (clip_en_i && above_q) ? shaped : m1_q;

  always_comb begin
    if (mute_i) begin
      res_d = '0;
    end else if (neg_q) begin
      if (magf > M1_W'(1 << (SAMPLE_BITS - 1))) begin
        res_d = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
        res_d = SAMPLE_BITS'(M1_W'(0) - magf);
      end
    end else begin
      if (magf > M1_W'((1 << (SAMPLE_BITS - 1)) - 1)) begin
        res_d = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end else begin
        res_d = magf[SAMPLE_BITS-1:0];
      end
    end
  end

  // free-running stage registers, input held by the datapath
  always_ff @(posedge clk_i) begin
    neg_q   <= neg;
    m1_q    <= prod[GAIN_FRAC_BITS +: M1_W];
    above_q <= above_d;
    sat_q   <= sat_d;
    diff_q  <= excess[DIFF_W-1:0];
    rmul_q  <= rmul_d;
    qest_q  <= qest;
    prodc_q <= prodc_d;
    over_q  <= over_d;
    a_q     <= a_d;
    dt_q    <= dt_d;
    fr_q    <= pos[16+RANGE_SH-1:RANGE_SH];
    p_q     <= p_d;
    t_q     <= t_d;
    tm_q    <= tm_d;
    res_q   <= res_d;
  end

  assign res_o = res_q;

endmodule

// ----- rtl/core/smscm_datapath.sv -----
module smscm_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  smscm_pkg::smscm_cmd_t             cmd_i,
  input  smscm_pkg::in_t                    in_data_i,
  input  logic                              cfg_we_i,
  input  logic [smscm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [smscm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output smscm_pkg::out_t                   out_data_o
);
  import smscm_pkg::*;

  logic [GAIN_W-1:0] gain_q;
  logic              mute_q;
  logic              clip_en_q;

  in_t     in_q;
  sample_t res_l, res_r;
  out_t    out_d, out_q;

  peak_t run_l_q, run_r_q, run_l_d, run_r_d;
  peak_t lvl_l_q, lvl_r_q, lvl_l_d, lvl_r_d;
  peak_t hold_l_q, hold_r_q, hold_l_d, hold_r_d;
  peak_t pk_l, pk_r, max_l, max_r;

  function automatic peak_t peak_of(sample_t s);
    logic [SAMPLE_BITS-1:0] m;
    m = s[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - SAMPLE_BITS'(s)) : SAMPLE_BITS'(s);
    if (m > SAMPLE_BITS'({PEAK_W{1'b1}})) begin
      return {PEAK_W{1'b1}};
    end
    return m[PEAK_W-1:0];
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q    <= GAIN_RESET;
      mute_q    <= 1'b0;
      clip_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MASTER_GAIN:  gain_q    <= cfg_data_i[GAIN_W-1:0];
        CFG_MASTER_MUTE:  mute_q    <= cfg_data_i[0];
        CFG_SOFT_CLIP_EN: clip_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input item held for the whole computation
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_data_i;
    end
  end

  smscm_lane u_lane_l (
    .clk_i     (clk_i),
    .sample_i  (in_q.left_in),
    .gain_i    (gain_q),
    .mute_i    (mute_q),
    .clip_en_i (clip_en_q),
    .res_o     (res_l)
  );

  smscm_lane u_lane_r (
    .clk_i     (clk_i),
    .sample_i  (in_q.right_in),
    .gain_i    (gain_q),
    .mute_i    (mute_q),
    .clip_en_i (clip_en_q),
    .res_o     (res_r)
  );

  // meter update and result assembly
  assign pk_l  = peak_of(res_l);
  assign pk_r  = peak_of(res_r);
  assign max_l = (pk_l > run_l_q) ? pk_l : run_l_q;
  assign max_r = (pk_r > run_r_q) ? pk_r : run_r_q;

  always_comb begin
    run_l_d  = run_l_q;
    run_r_d  = run_r_q;
    lvl_l_d  = lvl_l_q;
    lvl_r_d  = lvl_r_q;
    hold_l_d = hold_l_q;
    hold_r_d = hold_r_q;
    out_d    = '0;
    if (in_q.func) begin
      hold_l_d          = '0;
      hold_r_d          = '0;
      out_d.level_left  = lvl_l_q;
      out_d.level_right = lvl_r_q;
      out_d.hold_left   = hold_l_q;
      out_d.hold_right  = hold_r_q;
    end else begin
      if (in_q.last_of_block) begin
        lvl_l_d  = max_l;
        lvl_r_d  = max_r;
        hold_l_d = (max_l > hold_l_q) ? max_l : hold_l_q;
        hold_r_d = (max_r > hold_r_q) ? max_r : hold_r_q;
        run_l_d  = '0;
        run_r_d  = '0;
      end else begin
        run_l_d = max_l;
        run_r_d = max_r;
      end
      out_d.left_out    = res_l;
      out_d.right_out   = res_r;
      out_d.level_left  = lvl_l_d;
      out_d.level_right = lvl_r_d;
      out_d.hold_left   = hold_l_d;
      out_d.hold_right  = hold_r_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_l_q  <= '0;
      run_r_q  <= '0;
      lvl_l_q  <= '0;
      lvl_r_q  <= '0;
      hold_l_q <= '0;
      hold_r_q <= '0;
    end else if (cmd_i.load) begin
      run_l_q  <= run_l_d;
      run_r_q  <= run_r_d;
      lvl_l_q  <= lvl_l_d;
      lvl_r_q  <= lvl_r_d;
      hold_l_q <= hold_l_d;
      hold_r_q <= hold_r_d;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

// ----- rtl/core/smscm_ctrl.sv -----
module smscm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  out_ready_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  output smscm_pkg::smscm_cmd_t cmd_o
);
  import smscm_pkg::*;

  // lane stages between the held input and the lane result
  localparam int LAT   = 9;
  localparam int CNT_W = $clog2(LAT);

  ctrl_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CALC;
          cnt_d   = '0;
        end
      end
      ST_CALC: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(LAT - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_FIN: begin
        cmd_o.load = out_free;
      end
      default: ;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/core/stereo_master_soft_clip_meter_top.sv -----
// an item is held from its input transfer through the nine register stages of the
// per-channel gain, divide, tanh and saturate sequence, then loaded into the output
// register once that register is free; the next item is taken only after that load
// the output register holds a result while the next item is taken in
// reset: asynchronous active low, clears control state, meters and peak hold to zero
// and sets gain to unity, mute off and soft clip on
module stereo_master_soft_clip_meter_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  smscm_pkg::in_t                    in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output smscm_pkg::out_t                   out_data_o,
  input  logic                              cfg_we_i,
  input  logic [smscm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [smscm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import smscm_pkg::*;

  smscm_cmd_t cmd;

  // sequencing
  smscm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // arithmetic, meters and registers
  smscm_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_data_o (out_data_o)
  );

endmodule
